FILE: rtl/closest_point_on_triangle_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the closest point on triangle block
// Each macro checks one implication on the rising edge of clk while reset is
// not asserted.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants and types of the closest point on triangle block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpt_pkg;

	localparam int CPT_COORD_BITS = 32;
	localparam int CPT_LIMB_BITS = 32;

	typedef enum logic [2:0] {
		REG_VERT_A   = 3'd0,
		REG_VERT_B   = 3'd1,
		REG_EDGE_AB  = 3'd2,
		REG_VERT_C   = 3'd3,
		REG_EDGE_AC  = 3'd4,
		REG_EDGE_BC  = 3'd5,
		REG_INTERIOR = 3'd6
	} region_t;

	typedef struct packed {
		logic signed [CPT_COORD_BITS-1:0] query_x;
		logic signed [CPT_COORD_BITS-1:0] query_y;
		logic signed [CPT_COORD_BITS-1:0] query_z;
		logic signed [CPT_COORD_BITS-1:0] vert_a_x;
		logic signed [CPT_COORD_BITS-1:0] vert_a_y;
		logic signed [CPT_COORD_BITS-1:0] vert_a_z;
		logic signed [CPT_COORD_BITS-1:0] vert_b_x;
		logic signed [CPT_COORD_BITS-1:0] vert_b_y;
		logic signed [CPT_COORD_BITS-1:0] vert_b_z;
		logic signed [CPT_COORD_BITS-1:0] vert_c_x;
		logic signed [CPT_COORD_BITS-1:0] vert_c_y;
		logic signed [CPT_COORD_BITS-1:0] vert_c_z;
	} cpt_req_t;

	typedef struct packed {
		logic signed [CPT_COORD_BITS-1:0] near_x;
		logic signed [CPT_COORD_BITS-1:0] near_y;
		logic signed [CPT_COORD_BITS-1:0] near_z;
		region_t                          region;
		logic                             degenerate;
	} cpt_rsp_t;

endpackage

FILE: rtl/cpt_mul.sv
// ----------------------------------------------------------------------------
// cpt_mul
// Two-stage signed multiplier. The operands are cut into limbs, the limb
// products are registered, and their shifted sum is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpt_mul
	import cpt_pkg::*;
#(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int LB = CPT_LIMB_BITS;
	localparam int NA = (AW + LB - 1) / LB;
	localparam int NB = (BW + LB - 1) / LB;
	localparam int PW = AW + BW;

	logic signed [NA*LB-1:0] ax;
	logic signed [NB*LB-1:0] bx;
	logic signed [LB:0]      la [NA];
	logic signed [LB:0]      lb [NB];
	logic signed [2*LB+1:0]  pp_s1 [NA][NB];
	logic signed [PW-1:0]    acc;
	logic signed [PW-1:0]    p_s2;

	assign ax = (NA*LB)'(a);
	assign bx = (NB*LB)'(b);

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			la[i] = {(i == NA - 1) ? ax[i*LB+LB-1] : 1'b0, ax[i*LB +: LB]};
		end
		for (int j = 0; j < NB; j++) begin
			lb[j] = {(j == NB - 1) ? bx[j*LB+LB-1] : 1'b0, bx[j*LB +: LB]};
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (PW'(pp_s1[i][j]) <<< (LB * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= la[i] * lb[j];
				end
			end
			p_s2 <= acc;
		end
	end

	assign p = p_s2;

endmodule

FILE: rtl/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined restoring divider that produces one quotient bit per stage. The
// caller guarantees that the quotient fits in QB bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpt_div
	import cpt_pkg::*;
#(
	parameter int MW = 171,
	parameter int DW = 137,
	parameter int QB = 35
) (
	input  logic          clk,
	input  logic          en,
	input  logic [MW-1:0] m,
	input  logic [DW-1:0] d2,
	output logic [QB-1:0] q
);

	localparam int RW = DW + 1;

	logic [RW-1:0] rem_q  [QB];
	logic [QB-1:0] low_q  [QB];
	logic [QB-1:0] quo_q  [QB];
	logic [DW-1:0] div_q  [QB];
	logic [RW-1:0] rem_in [QB];
	logic [RW-1:0] trial  [QB];
	logic [QB-1:0] low_in [QB];
	logic [QB-1:0] quo_in [QB];
	logic [DW-1:0] div_in [QB];
	logic          fit    [QB];

	always_comb begin
		rem_in[0] = RW'(m >> QB);
		low_in[0] = m[QB-1:0];
		quo_in[0] = '0;
		div_in[0] = d2;
		for (int k = 1; k < QB; k++) begin
			rem_in[k] = rem_q[k-1];
			low_in[k] = low_q[k-1];
			quo_in[k] = quo_q[k-1];
			div_in[k] = div_q[k-1];
		end
		for (int k = 0; k < QB; k++) begin
			trial[k] = {rem_in[k][RW-2:0], low_in[k][QB-1]};
			fit[k]   = (trial[k] >= RW'(div_in[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB; k++) begin
				rem_q[k] <= fit[k] ? (trial[k] - RW'(div_in[k])) : trial[k];
				quo_q[k] <= {quo_in[k][QB-2:0], fit[k]};
				low_q[k] <= {low_in[k][QB-2:0], 1'b0};
				div_q[k] <= div_in[k];
			end
		end
	end

	assign q = quo_q[QB-1];

endmodule

FILE: rtl/closest_point_on_triangle.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle
// The divider adds one stage per quotient bit and forms most of the pipeline.
// Throughput is one request per cycle; the whole pipeline holds while a
// result waits under stall. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "closest_point_on_triangle_assert.svh"

module closest_point_on_triangle
	import cpt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  cpt_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output cpt_rsp_t rsp
);

	localparam int CB   = CPT_COORD_BITS;
	localparam int DW   = CB + 1;
	localparam int PW1  = 2 * DW;
	localparam int SW   = PW1 + 2;
	localparam int EW   = SW + 1;
	localparam int KW   = PW1 + 1;
	localparam int DTW  = 2 * SW + 1;
	localparam int NNW  = 2 * KW + 2;
	localparam int TW   = DW + KW + 2;
	localparam int FW   = TW;
	localparam int VW   = KW;
	localparam int NW   = FW + VW;
	localparam int DNW  = NNW;
	localparam int MW   = NW + 2;
	localparam int D2W  = DNW + 1;
	localparam int QB   = CB + 3;
	localparam int RSW  = QB + 2;
	localparam int LAT  = QB + 12;
	localparam int DET_A [6] = '{0, 2, 4, 0, 2, 4};
	localparam int DET_B [6] = '{3, 1, 1, 5, 5, 3};
	localparam logic signed [RSW-1:0] SAT_HI = RSW'((longint'(1) <<< (CB - 1)) - 1);
	localparam logic signed [RSW-1:0] SAT_LO = -SAT_HI - RSW'(1);

	typedef struct packed {
		logic [2:0][CB-1:0] pa;
		logic [2:0][CB-1:0] pb;
		logic [2:0][CB-1:0] pq;
		logic [2:0][DW-1:0] ab;
		logic [2:0][DW-1:0] ac;
		logic [2:0][DW-1:0] bc;
		logic [2:0][DW-1:0] aq;
	} geo_t;

	typedef struct packed {
		logic [DNW-1:0]     den;
		logic [2:0][CB-1:0] base;
		logic [2:0]         neg;
		logic               sub;
		logic               dz;
		logic               deg;
		region_t            region;
	} tail_t;

	logic           en;
	logic [LAT-1:0] v_q;

	logic signed [CB-1:0] qi [3];
	logic signed [CB-1:0] ai [3];
	logic signed [CB-1:0] bi [3];
	logic signed [CB-1:0] ci [3];
	geo_t                 geo_n;
	logic signed [DW-1:0] bq_n [3];
	logic signed [DW-1:0] cq_n [3];

	geo_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6, geo_s7;
	logic signed [DW-1:0] bq_s1 [3];
	logic signed [DW-1:0] cq_s1 [3];

	logic signed [DW-1:0]  m1a [6][3];
	logic signed [DW-1:0]  m1b [6][3];
	logic signed [PW1-1:0] dot_p [6][3];
	logic signed [PW1-1:0] cx_p [3];
	logic signed [PW1-1:0] cx_n [3];

	logic signed [SW-1:0] s_s4 [6];
	logic signed [SW-1:0] s_s5 [6];
	logic signed [SW-1:0] s_s6 [6];
	logic signed [SW-1:0] s_s7 [6];
	logic signed [KW-1:0] kn_s4 [3];
	logic signed [KW-1:0] kn_s5 [3];
	logic signed [KW-1:0] kn_s6 [3];
	logic signed [KW-1:0] kn_s7 [3];
	logic signed [EW-1:0] e_s5 [2];
	logic signed [EW-1:0] e_s6 [2];
	logic signed [EW-1:0] e_s7 [2];

	logic signed [2*SW-1:0]  dp [6];
	logic signed [2*KW-1:0]  nn_p [3];
	logic signed [DW+KW-1:0] t_p [3];
	logic signed [DTW-1:0]   det [3];

	logic                 dle_s7 [3];
	logic signed [NNW-1:0] nn_s7;
	logic signed [TW-1:0]  t_s7;
	logic signed [EW-1:0]  dab_s7;
	logic signed [EW-1:0]  dac_s7;
	logic signed [EW:0]    dbc_s7;

	logic signed [FW-1:0] f_n;
	logic signed [VW-1:0] vec_n [3];
	tail_t                tail_n;
	logic signed [FW-1:0] f_s8;
	logic signed [VW-1:0] vec_s8 [3];
	tail_t                tail_s8, tail_s9, tail_s10, tail_s11;
	tail_t                tail_sgn;
	logic signed [NW-1:0] num_p [3];

	logic [MW-1:0]  m_s11 [3];
	logic [D2W-1:0] d2_s11;
	logic [QB-1:0]  q_d [3];
	tail_t          tail_dly_q [QB];

	tail_t                 tf;
	logic [QB-1:0]         qv [3];
	logic signed [RSW-1:0] qx [3];
	logic signed [RSW-1:0] bx [3];
	logic signed [RSW-1:0] rs [3];
	logic signed [CB-1:0]  sat_v [3];
	cpt_rsp_t              rsp_n;
	cpt_rsp_t              rsp_q;

	assign en        = !(v_q[LAT-1] && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = v_q[LAT-1];
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], req_valid};
		end
	end

	always_comb begin
		qi[0] = req.query_x;  qi[1] = req.query_y;  qi[2] = req.query_z;
		ai[0] = req.vert_a_x; ai[1] = req.vert_a_y; ai[2] = req.vert_a_z;
		bi[0] = req.vert_b_x; bi[1] = req.vert_b_y; bi[2] = req.vert_b_z;
		ci[0] = req.vert_c_x; ci[1] = req.vert_c_y; ci[2] = req.vert_c_z;
		for (int i = 0; i < 3; i++) begin
			geo_n.pa[i] = ai[i];
			geo_n.pb[i] = bi[i];
			geo_n.pq[i] = qi[i];
			geo_n.ab[i] = DW'(bi[i]) - DW'(ai[i]);
			geo_n.ac[i] = DW'(ci[i]) - DW'(ai[i]);
			geo_n.bc[i] = DW'(ci[i]) - DW'(bi[i]);
			geo_n.aq[i] = DW'(qi[i]) - DW'(ai[i]);
			bq_n[i]     = DW'(qi[i]) - DW'(bi[i]);
			cq_n[i]     = DW'(qi[i]) - DW'(ci[i]);
		end
	end

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			for (int i = 0; i < 3; i++) begin
				m1a[j][i] = (j % 2 == 0) ? $signed(geo_s1.ab[i]) : $signed(geo_s1.ac[i]);
				if (j / 2 == 0) begin
					m1b[j][i] = $signed(geo_s1.aq[i]);
				end else if (j / 2 == 1) begin
					m1b[j][i] = bq_s1[i];
				end else begin
					m1b[j][i] = cq_s1[i];
				end
			end
		end
	end

	for (genvar j = 0; j < 6; j++) begin : g_dot
		for (genvar i = 0; i < 3; i++) begin : g_comp
			cpt_mul #(.AW(DW), .BW(DW)) u_dot (
				.clk (clk),
				.en  (en),
				.a   (m1a[j][i]),
				.b   (m1b[j][i]),
				.p   (dot_p[j][i])
			);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_cross
		cpt_mul #(.AW(DW), .BW(DW)) u_cxp (
			.clk (clk),
			.en  (en),
			.a   (geo_s1.ab[(i+1)%3]),
			.b   (geo_s1.ac[(i+2)%3]),
			.p   (cx_p[i])
		);
		cpt_mul #(.AW(DW), .BW(DW)) u_cxn (
			.clk (clk),
			.en  (en),
			.a   (geo_s1.ab[(i+2)%3]),
			.b   (geo_s1.ac[(i+1)%3]),
			.p   (cx_n[i])
		);
	end

	for (genvar k = 0; k < 6; k++) begin : g_det
		cpt_mul #(.AW(SW), .BW(SW)) u_det (
			.clk (clk),
			.en  (en),
			.a   (s_s4[DET_A[k]]),
			.b   (s_s4[DET_B[k]]),
			.p   (dp[k])
		);
	end

	for (genvar i = 0; i < 3; i++) begin : g_norm
		cpt_mul #(.AW(KW), .BW(KW)) u_nn (
			.clk (clk),
			.en  (en),
			.a   (kn_s4[i]),
			.b   (kn_s4[i]),
			.p   (nn_p[i])
		);
		cpt_mul #(.AW(DW), .BW(KW)) u_t (
			.clk (clk),
			.en  (en),
			.a   (geo_s4.aq[i]),
			.b   (kn_s4[i]),
			.p   (t_p[i])
		);
		cpt_mul #(.AW(FW), .BW(VW)) u_num (
			.clk (clk),
			.en  (en),
			.a   (f_s8),
			.b   (vec_s8[i]),
			.p   (num_p[i])
		);
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			det[k] = DTW'(dp[2*k]) - DTW'(dp[2*k+1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1 <= geo_n;
			for (int i = 0; i < 3; i++) begin
				bq_s1[i] <= bq_n[i];
				cq_s1[i] <= cq_n[i];
			end
			geo_s2 <= geo_s1;
			geo_s3 <= geo_s2;
			geo_s4 <= geo_s3;
			geo_s5 <= geo_s4;
			geo_s6 <= geo_s5;
			geo_s7 <= geo_s6;
			for (int j = 0; j < 6; j++) begin
				s_s4[j] <= SW'(dot_p[j][0]) + SW'(dot_p[j][1]) + SW'(dot_p[j][2]);
				s_s5[j] <= s_s4[j];
				s_s6[j] <= s_s5[j];
				s_s7[j] <= s_s6[j];
			end
			for (int i = 0; i < 3; i++) begin
				kn_s4[i] <= KW'(cx_p[i]) - KW'(cx_n[i]);
				kn_s5[i] <= kn_s4[i];
				kn_s6[i] <= kn_s5[i];
				kn_s7[i] <= kn_s6[i];
			end
			e_s5[0] <= EW'(s_s4[3]) - EW'(s_s4[2]);
			e_s5[1] <= EW'(s_s4[4]) - EW'(s_s4[5]);
			e_s6    <= e_s5;
			e_s7    <= e_s6;
			for (int k = 0; k < 3; k++) begin
				dle_s7[k] <= (det[k] <= 0);
			end
			nn_s7  <= NNW'(nn_p[0]) + NNW'(nn_p[1]) + NNW'(nn_p[2]);
			t_s7   <= TW'(t_p[0]) + TW'(t_p[1]) + TW'(t_p[2]);
			dab_s7 <= EW'(s_s6[0]) - EW'(s_s6[2]);
			dac_s7 <= EW'(s_s6[1]) - EW'(s_s6[5]);
			dbc_s7 <= (EW+1)'(e_s6[0]) + (EW+1)'(e_s6[1]);
		end
	end

	always_comb begin
		f_n          = t_s7;
		tail_n.den   = DNW'(nn_s7);
		tail_n.base  = geo_s7.pq;
		tail_n.neg   = '0;
		tail_n.sub   = 1'b1;
		tail_n.region = REG_INTERIOR;
		for (int i = 0; i < 3; i++) begin
			vec_n[i] = kn_s7[i];
		end
		priority if (s_s7[0] <= 0 && s_s7[1] <= 0) begin
			tail_n.region = REG_VERT_A;
			tail_n.base   = geo_s7.pa;
			tail_n.den    = '0;
			tail_n.sub    = 1'b0;
			f_n           = '0;
		end else if (s_s7[2] >= 0 && e_s7[0] <= 0) begin
			tail_n.region = REG_VERT_B;
			tail_n.base   = geo_s7.pb;
			tail_n.den    = '0;
			tail_n.sub    = 1'b0;
			f_n           = '0;
		end else if (dle_s7[0] && s_s7[0] >= 0 && s_s7[2] <= 0) begin
			tail_n.region = REG_EDGE_AB;
			tail_n.base   = geo_s7.pa;
			tail_n.den    = DNW'(dab_s7);
			tail_n.sub    = 1'b0;
			f_n           = FW'(s_s7[0]);
			for (int i = 0; i < 3; i++) begin
				vec_n[i] = VW'($signed(geo_s7.ab[i]));
			end
		end else if (s_s7[5] >= 0 && e_s7[1] <= 0) begin
			tail_n.region = REG_VERT_C;
			tail_n.base   = geo_s7.pa;
			for (int i = 0; i < 3; i++) begin
				tail_n.base[i] = CB'(geo_s7.pa[i] + geo_s7.ac[i]);
			end
			tail_n.den    = '0;
			tail_n.sub    = 1'b0;
			f_n           = '0;
		end else if (dle_s7[1] && s_s7[1] >= 0 && s_s7[5] <= 0) begin
			tail_n.region = REG_EDGE_AC;
			tail_n.base   = geo_s7.pa;
			tail_n.den    = DNW'(dac_s7);
			tail_n.sub    = 1'b0;
			f_n           = FW'(s_s7[1]);
			for (int i = 0; i < 3; i++) begin
				vec_n[i] = VW'($signed(geo_s7.ac[i]));
			end
		end else if (dle_s7[2] && e_s7[0] >= 0 && e_s7[1] >= 0) begin
			tail_n.region = REG_EDGE_BC;
			tail_n.base   = geo_s7.pb;
			tail_n.den    = DNW'(dbc_s7);
			tail_n.sub    = 1'b0;
			f_n           = FW'(e_s7[0]);
			for (int i = 0; i < 3; i++) begin
				vec_n[i] = VW'($signed(geo_s7.bc[i]));
			end
		end else begin
			tail_n.region = REG_INTERIOR;
		end
		tail_n.dz  = (tail_n.den == '0);
		tail_n.deg = (tail_n.region == REG_INTERIOR) && tail_n.dz;
	end

	always_comb begin
		tail_sgn = tail_s10;
		for (int i = 0; i < 3; i++) begin
			tail_sgn.neg[i] = num_p[i][NW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s8     <= f_n;
			vec_s8   <= vec_n;
			tail_s8  <= tail_n;
			tail_s9  <= tail_s8;
			tail_s10 <= tail_s9;
			tail_s11 <= tail_sgn;
			for (int i = 0; i < 3; i++) begin
				if (num_p[i][NW-1]) begin
					m_s11[i] <= MW'(tail_s10.den) - (MW'(num_p[i]) <<< 1);
				end else begin
					m_s11[i] <= MW'(tail_s10.den) + (MW'(num_p[i]) <<< 1);
				end
			end
			d2_s11 <= {tail_s10.den, 1'b0};
			tail_dly_q[0] <= tail_s11;
			for (int k = 1; k < QB; k++) begin
				tail_dly_q[k] <= tail_dly_q[k-1];
			end
			rsp_q <= rsp_n;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		cpt_div #(.MW(MW), .DW(D2W), .QB(QB)) u_div (
			.clk (clk),
			.en  (en),
			.m   (m_s11[i]),
			.d2  (d2_s11),
			.q   (q_d[i])
		);
	end

	always_comb begin
		tf = tail_dly_q[QB-1];
		for (int i = 0; i < 3; i++) begin
			qv[i] = tf.dz ? '0 : q_d[i];
			qx[i] = RSW'(qv[i]);
			bx[i] = RSW'($signed(tf.base[i]));
			rs[i] = (tf.neg[i] ^ tf.sub) ? (bx[i] - qx[i]) : (bx[i] + qx[i]);
			if (rs[i] > SAT_HI) begin
				sat_v[i] = CB'(SAT_HI);
			end else if (rs[i] < SAT_LO) begin
				sat_v[i] = CB'(SAT_LO);
			end else begin
				sat_v[i] = CB'(rs[i]);
			end
		end
		rsp_n.near_x     = sat_v[0];
		rsp_n.near_y     = sat_v[1];
		rsp_n.near_z     = sat_v[2];
		rsp_n.region     = tf.region;
		rsp_n.degenerate = tf.deg;
	end

	`CPT_ASSERT_NOW(a_backpressure, rsp_valid && rsp_stall, req_stall,
		"request taken while a result is stalled")
	`CPT_ASSERT_NEXT(a_freeze, rsp_valid && rsp_stall, $stable(v_q),
		"pipeline moved while a result is stalled")
	`CPT_ASSERT_NOW(a_vertex_zero, v_q[7] && (tail_s8.region == REG_VERT_A ||
		tail_s8.region == REG_VERT_B || tail_s8.region == REG_VERT_C), tail_s8.dz,
		"vertex region without a zero divisor")
	`CPT_ASSERT_NOW(a_degenerate, rsp_valid && rsp.degenerate, rsp.region == REG_INTERIOR,
		"degenerate flag outside the interior region")

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for closest_point_on_triangle. Directed triangles
// reach every Voronoi region, the coordinate extremes and zero-length edges.
// Random requests follow, mixing full-range, small and collinear geometry.
// A scoreboard predicts each result in exact wide integers and compares it
// field by field. Both handshakes idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import cpt_pkg::*;

	typedef logic signed [255:0] wide_t;

	localparam int N_RANDOM = 630;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 60;
	localparam int ONE = 32'sh0001_0000;

	class closest_point_board;
		cpt_rsp_t pending[$];
		int mismatches;

		function wide_t dot3(wide_t ux, wide_t uy, wide_t uz, wide_t vx, wide_t vy, wide_t vz);
			return ux * vx + uy * vy + uz * vz;
		endfunction

		function wide_t round_div(wide_t num, wide_t den);
			wide_t mag;
			wide_t q;
			if (den == 0)
				return 0;
			mag = (num < 0) ? -num : num;
			q = (2 * mag + den) / (2 * den);
			return (num < 0) ? -q : q;
		endfunction

		function logic signed [31:0] clamp(wide_t v);
			if (v > wide_t'(64'sd2147483647))
				return 32'sh7fff_ffff;
			if (v < -wide_t'(64'sd2147483648))
				return 32'sh8000_0000;
			return v[31:0];
		endfunction

		function cpt_rsp_t nearest_point(cpt_req_t r);
			wide_t q[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], aq[3], bq[3], cq[3];
			wide_t kn[3], pt[3];
			wide_t s1, s2, s3, s4, s5, s6, e1, e2, den, nn, t;
			cpt_rsp_t o;
			q = '{r.query_x, r.query_y, r.query_z};
			a = '{r.vert_a_x, r.vert_a_y, r.vert_a_z};
			b = '{r.vert_b_x, r.vert_b_y, r.vert_b_z};
			c = '{r.vert_c_x, r.vert_c_y, r.vert_c_z};
			for (int i = 0; i < 3; i++) begin
				ab[i] = b[i] - a[i];
				ac[i] = c[i] - a[i];
				bc[i] = c[i] - b[i];
				aq[i] = q[i] - a[i];
				bq[i] = q[i] - b[i];
				cq[i] = q[i] - c[i];
			end
			s1 = dot3(ab[0], ab[1], ab[2], aq[0], aq[1], aq[2]);
			s2 = dot3(ac[0], ac[1], ac[2], aq[0], aq[1], aq[2]);
			s3 = dot3(ab[0], ab[1], ab[2], bq[0], bq[1], bq[2]);
			s4 = dot3(ac[0], ac[1], ac[2], bq[0], bq[1], bq[2]);
			s5 = dot3(ab[0], ab[1], ab[2], cq[0], cq[1], cq[2]);
			s6 = dot3(ac[0], ac[1], ac[2], cq[0], cq[1], cq[2]);
			e1 = s4 - s3;
			e2 = s5 - s6;
			o.degenerate = 1'b0;
			if (s1 <= 0 && s2 <= 0) begin
				o.region = REG_VERT_A;
				pt = a;
			end else if (s3 >= 0 && e1 <= 0) begin
				o.region = REG_VERT_B;
				pt = b;
			end else if (s1 * s4 - s3 * s2 <= 0 && s1 >= 0 && s3 <= 0) begin
				o.region = REG_EDGE_AB;
				den = s1 - s3;
				for (int i = 0; i < 3; i++)
					pt[i] = a[i] + round_div(s1 * ab[i], den);
			end else if (s6 >= 0 && e2 <= 0) begin
				o.region = REG_VERT_C;
				pt = c;
			end else if (s5 * s2 - s1 * s6 <= 0 && s2 >= 0 && s6 <= 0) begin
				o.region = REG_EDGE_AC;
				den = s2 - s6;
				for (int i = 0; i < 3; i++)
					pt[i] = a[i] + round_div(s2 * ac[i], den);
			end else if (s3 * s6 - s5 * s4 <= 0 && e1 >= 0 && e2 >= 0) begin
				o.region = REG_EDGE_BC;
				den = e1 + e2;
				for (int i = 0; i < 3; i++)
					pt[i] = b[i] + round_div(e1 * bc[i], den);
			end else begin
				o.region = REG_INTERIOR;
				kn[0] = ab[1] * ac[2] - ab[2] * ac[1];
				kn[1] = ab[2] * ac[0] - ab[0] * ac[2];
				kn[2] = ab[0] * ac[1] - ab[1] * ac[0];
				nn = dot3(kn[0], kn[1], kn[2], kn[0], kn[1], kn[2]);
				if (nn == 0) begin
					o.degenerate = 1'b1;
					pt = q;
				end else begin
					t = dot3(aq[0], aq[1], aq[2], kn[0], kn[1], kn[2]);
					for (int i = 0; i < 3; i++)
						pt[i] = q[i] - round_div(t * kn[i], nn);
				end
			end
			o.near_x = clamp(pt[0]);
			o.near_y = clamp(pt[1]);
			o.near_z = clamp(pt[2]);
			return o;
		endfunction

		function void note_request(cpt_req_t r);
			pending.push_back(nearest_point(r));
		endfunction

		function void check_result(cpt_rsp_t got);
			cpt_rsp_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got.near_x !== exp.near_x || got.near_y !== exp.near_y ||
			    got.near_z !== exp.near_z || got.region !== exp.region ||
			    got.degenerate !== exp.degenerate) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %0d %0d %0d r%0d d%0b, got %0d %0d %0d r%0d d%0b",
						exp.near_x, exp.near_y, exp.near_z, exp.region, exp.degenerate,
						got.near_x, got.near_y, got.near_z, got.region, got.degenerate);
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	cpt_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	cpt_rsp_t rsp;

	closest_point_board board;
	bit burst;
	int idle_cycles;

	closest_point_on_triangle u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		burst = 1'b0;
		idle_cycles = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				board.note_request(req);
			if (rsp_valid && !rsp_stall)
				board.check_result(rsp);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[closest_point_on_triangle] ERROR");
				$finish;
			end
		end
	end

	function automatic int draw_gap();
		return burst ? 0 : $urandom_range(0, 13);
	endfunction

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = draw_gap();
			if (n > 0) begin
				rsp_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			rsp_stall = 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	task automatic send_request(cpt_req_t r);
		int n;
		n = draw_gap();
		if (n > 0) begin
			req_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic send_geometry(int qx, int qy, int qz, int ax, int ay, int az,
		int bx, int by, int bz, int cx, int cy, int cz);
		cpt_req_t r;
		r = '{qx, qy, qz, ax, ay, az, bx, by, bz, cx, cy, cz};
		send_request(r);
	endtask

	function automatic int small_coord();
		return $signed($urandom_range(0, 32 * ONE)) - 16 * ONE;
	endfunction

	task automatic send_random();
		cpt_req_t r;
		int k;
		k = $urandom_range(0, 9);
		if (k < 3) begin
			r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			r = {small_coord(), small_coord(), small_coord(), small_coord(),
				small_coord(), small_coord(), small_coord(), small_coord(),
				small_coord(), small_coord(), small_coord(), small_coord()};
			if (k == 7) begin
				r.vert_c_x = r.vert_a_x + 2 * (r.vert_b_x - r.vert_a_x);
				r.vert_c_y = r.vert_a_y + 2 * (r.vert_b_y - r.vert_a_y);
				r.vert_c_z = r.vert_a_z + 2 * (r.vert_b_z - r.vert_a_z);
			end else if (k == 8) begin
				r.vert_b_x = r.vert_a_x;
				r.vert_b_y = r.vert_a_y;
				r.vert_b_z = r.vert_a_z;
			end else if (k == 9) begin
				r.vert_a_z = 0;
				r.vert_b_z = 0;
				r.vert_c_z = 0;
			end
		end
		send_request(r);
	endtask

	initial begin
		int big;
		int tiny;
		big = 32'sh7fff_ffff;
		tiny = 32'sh8000_0000;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_geometry(-ONE, -ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
		send_geometry(5*ONE, -ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
		send_geometry(2*ONE, -ONE, 3, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
		send_geometry(-ONE, 5*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
		send_geometry(-ONE, 2*ONE, 7, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
		send_geometry(3*ONE, 3*ONE, -ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
		send_geometry(ONE, ONE, 5*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
		send_geometry(1, 1, 1, 0, 0, 0, 3, 0, 0, 0, 3, 0);
		send_geometry(big, big, big, big, big, big, big, big, big, big, big, big);
		send_geometry(tiny, tiny, tiny, tiny, tiny, tiny, tiny, tiny, tiny,
			tiny, tiny, tiny);
		send_geometry(big, tiny, big, tiny, big, tiny, big, tiny, tiny, tiny, big, big);
		send_geometry(tiny, big, 0, big, tiny, big, tiny, tiny, big, big, big, tiny);
		send_geometry(0, 0, big, tiny, tiny, 0, big, tiny, 0, 0, big, 0);
		send_geometry(0, 0, tiny, tiny, tiny, big, big, tiny, big, 0, big, big);
		send_geometry(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0, 4*ONE, 0, 0);
		send_geometry(ONE, ONE, ONE, 0, 0, 0, 4*ONE, 0, 0, 4*ONE, 0, 0);
		send_geometry(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_geometry(ONE, 3*ONE, 0, 0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE);
		send_geometry(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_geometry(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);

		for (int i = 0; i < N_RANDOM; i++) begin
			burst = ((i / 64) % 4) == 1;
			send_random();
		end
		burst = 1'b0;
		req_valid = 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("[closest_point_on_triangle] OK");
		else
			$display("[closest_point_on_triangle] ERROR");
		$finish;
	end

endmodule
